/* hw/rtl/pwmpc_pkg.sv */
// Package for the PWM channel panel controller.
// Holds the shared constants, action codes and the controller command struct.
// No dependencies.
`timescale 1ns / 1ps

package pwmpc_pkg;

  localparam int CHANNELS_DEF  = 24;
  localparam int DUTY_BITS_DEF = 10;

  localparam int CFG_STEP_W  = 6;
  localparam int CFG_LIMIT_W = 10;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_STEP_W-1:0]  STEP_RESET  = 6'd10;
  localparam logic [CFG_LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

  localparam logic REG_COARSE_STEP = 1'b0;
  localparam logic REG_DUTY_LIMIT  = 1'b1;

  localparam logic [1:0] ACT_PLUS   = 2'd0;
  localparam logic [1:0] ACT_MINUS  = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

endpackage

/* hw/rtl/pwm_channel_panel_controller.sv */
// An accepted word is captured, then executed when no result waits or the waiting one
// is taken; its result word is registered at execution, and no new word is taken before.
// A new word is accepted while the previous result still waits on the master side.
// Reset: asynchronous, active low; duties go to half scale, channel 0 selected,
// all outputs enabled, held latch mask on channel 0, registers to their defaults.
`timescale 1ns / 1ps

module pwm_channel_panel_controller #(
  parameter int CHANNELS  = pwmpc_pkg::CHANNELS_DEF,
  parameter int DUTY_BITS = pwmpc_pkg::DUTY_BITS_DEF,
  parameter int CW        = (CHANNELS > 2) ? $clog2(CHANNELS) : 1,
  parameter int OUT_BITS  = CW + 2 * DUTY_BITS + 2 * CHANNELS + 2,
  parameter int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: action[1:0], select_mode, coarse, zero padding.
  input  logic [7:0]                        s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: channel, duty, channel_active, duty_word, latch_mask,
  // latch_pulse, oe_mask, zero padding.
  output logic [OUT_W-1:0]                  m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pwmpc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pwmpc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pwmpc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import pwmpc_pkg::*;

  cmd_t                   cmd;
  logic [CFG_STEP_W-1:0]  coarse_step;
  logic [CFG_LIMIT_W-1:0] duty_limit;
  logic [CW-1:0]          channel;
  logic [DUTY_BITS-1:0]   duty;
  logic                   channel_active;
  logic [DUTY_BITS-1:0]   duty_word;
  logic [CHANNELS-1:0]    latch_mask;
  logic                   latch_pulse;
  logic [CHANNELS-1:0]    oe_mask;

  pwmpc_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .coarse_step_o (coarse_step),
    .duty_limit_o  (duty_limit)
  );

  pwmpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .cmd_o       (cmd)
  );

  pwmpc_dp #(
    .CHANNELS  (CHANNELS),
    .DUTY_BITS (DUTY_BITS),
    .CW        (CW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (s_tdata[1:0]),
    .select_mode_i    (s_tdata[2]),
    .coarse_i         (s_tdata[3]),
    .coarse_step_i    (coarse_step),
    .duty_limit_i     (duty_limit),
    .channel_o        (channel),
    .duty_o           (duty),
    .channel_active_o (channel_active),
    .duty_word_o      (duty_word),
    .latch_mask_o     (latch_mask),
    .latch_pulse_o    (latch_pulse),
    .oe_mask_o        (oe_mask)
  );

  assign m_tdata = OUT_W'({oe_mask, latch_pulse, latch_mask, duty_word,
                           channel_active, duty, channel});

endmodule

/* hw/rtl/pwmpc_cfg.sv */
// Configuration register file of the PWM channel panel controller.
// APB write and read of the coarse step and duty limit registers.
// Depends on pwmpc_pkg.
`timescale 1ns / 1ps

module pwmpc_cfg (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [pwmpc_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [pwmpc_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [pwmpc_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                     pready,
  output logic [pwmpc_pkg::CFG_STEP_W-1:0]         coarse_step_o,
  output logic [pwmpc_pkg::CFG_LIMIT_W-1:0]        duty_limit_o
);
  import pwmpc_pkg::*;

  logic [CFG_STEP_W-1:0]  coarse_step_q, coarse_step_d;
  logic [CFG_LIMIT_W-1:0] duty_limit_q, duty_limit_d;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    coarse_step_d = coarse_step_q;
    duty_limit_d  = duty_limit_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_COARSE_STEP: coarse_step_d = pwdata[CFG_STEP_W-1:0];
        REG_DUTY_LIMIT:  duty_limit_d  = pwdata[CFG_LIMIT_W-1:0];
        default:         coarse_step_d = coarse_step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coarse_step_q <= STEP_RESET;
      duty_limit_q  <= LIMIT_RESET;
    end else begin
      coarse_step_q <= coarse_step_d;
      duty_limit_q  <= duty_limit_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COARSE_STEP: prdata = APB_DATA_W'(coarse_step_q);
      REG_DUTY_LIMIT:  prdata = APB_DATA_W'(duty_limit_q);
      default:         prdata = '0;
    endcase
  end

  assign coarse_step_o = coarse_step_q;
  assign duty_limit_o  = duty_limit_q;

endmodule

/* hw/rtl/pwmpc_ctrl.sv */
// Controller state machine of the PWM channel panel controller.
// Sequences input capture, execution and the output word handshake.
// Depends on pwmpc_pkg.
`timescale 1ns / 1ps

module pwmpc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pwmpc_pkg::cmd_t  cmd_o
);
  import pwmpc_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  cmd_t cmd;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.exec    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* hw/rtl/pwmpc_dp.sv */
// Datapath of the PWM channel panel controller.
// Holds the duty store, selection, enable mask, held latch words and the result register.
// Depends on pwmpc_pkg.
`timescale 1ns / 1ps

module pwmpc_dp #(
  parameter int CHANNELS  = pwmpc_pkg::CHANNELS_DEF,
  parameter int DUTY_BITS = pwmpc_pkg::DUTY_BITS_DEF,
  parameter int CW        = (CHANNELS > 2) ? $clog2(CHANNELS) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pwmpc_pkg::cmd_t                    cmd_i,
  input  logic [1:0]                         action_i,
  input  logic                               select_mode_i,
  input  logic                               coarse_i,
  input  logic [pwmpc_pkg::CFG_STEP_W-1:0]   coarse_step_i,
  input  logic [pwmpc_pkg::CFG_LIMIT_W-1:0]  duty_limit_i,
  output logic [CW-1:0]                      channel_o,
  output logic [DUTY_BITS-1:0]               duty_o,
  output logic                               channel_active_o,
  output logic [DUTY_BITS-1:0]               duty_word_o,
  output logic [CHANNELS-1:0]                latch_mask_o,
  output logic                               latch_pulse_o,
  output logic [CHANNELS-1:0]                oe_mask_o
);
  import pwmpc_pkg::*;

  localparam int AW = ((DUTY_BITS > CFG_LIMIT_W) ? DUTY_BITS : CFG_LIMIT_W) + 1;
  localparam logic [AW-1:0]        DUTY_MAX  = AW'((1 << DUTY_BITS) - 1);
  localparam logic [AW-1:0]        CH_TOP    = AW'(CHANNELS - 1);
  localparam logic [DUTY_BITS-1:0] DUTY_HALF = DUTY_BITS'(1 << (DUTY_BITS - 1));

  function automatic logic [AW-1:0] bump(logic [AW-1:0] v, logic [AW-1:0] step,
                                         logic down, logic [AW-1:0] top);
    logic [AW-1:0] r;
    if (down) begin
      r = (v < step) ? '0 : v - step;
    end else begin
      r = v + step;
    end
    return (r > top) ? top : r;
  endfunction

  logic [1:0]           act_q;
  logic                 mode_q;
  logic                 coarse_q;

  logic [DUTY_BITS-1:0] duty_q [CHANNELS];
  logic [CW-1:0]        sel_q, sel_d;
  logic [CHANNELS-1:0]  en_q, en_d;
  logic [DUTY_BITS-1:0] hword_q, hword_d;
  logic [CHANNELS-1:0]  hmask_q, hmask_d;

  logic [AW-1:0]        step, lim, sel_bump, duty_bump;
  logic                 down, bump_act, duty_wr;
  logic [CHANNELS-1:0]  sel_hot;
  logic [DUTY_BITS-1:0] duty_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q    <= action_i;
      mode_q   <= select_mode_i;
      coarse_q <= coarse_i;
    end
  end

  always_comb begin
    step      = coarse_q ? AW'(coarse_step_i) : AW'(1);
    lim       = (AW'(duty_limit_i) > DUTY_MAX) ? DUTY_MAX : AW'(duty_limit_i);
    down      = (act_q == ACT_MINUS);
    bump_act  = (act_q == ACT_PLUS) || (act_q == ACT_MINUS);
    sel_hot   = CHANNELS'(1) << sel_q;
    sel_bump  = bump(AW'(sel_q), step, down, CH_TOP);
    duty_bump = bump(AW'(duty_q[sel_q]), step, down, lim);

    sel_d   = sel_q;
    en_d    = en_q;
    hword_d = hword_q;
    hmask_d = hmask_q;
    duty_wr = 1'b0;
    if (bump_act) begin
      if (mode_q) begin
        sel_d = sel_bump[CW-1:0];
      end else begin
        duty_wr = 1'b1;
        hword_d = duty_bump[DUTY_BITS-1:0];
        hmask_d = sel_hot;
      end
    end else if (act_q == ACT_TOGGLE) begin
      en_d = en_q ^ sel_hot;
    end
    duty_new = duty_wr ? hword_d : duty_q[sel_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        duty_q[i] <= DUTY_HALF;
      end
      sel_q   <= '0;
      en_q    <= '1;
      hword_q <= DUTY_HALF;
      hmask_q <= CHANNELS'(1);
    end else if (cmd_i.exec) begin
      if (duty_wr) begin
        duty_q[sel_q] <= hword_d;
      end
      sel_q   <= sel_d;
      en_q    <= en_d;
      hword_q <= hword_d;
      hmask_q <= hmask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      channel_o        <= sel_d;
      duty_o           <= duty_new;
      channel_active_o <= en_d[sel_d];
      duty_word_o      <= hword_d;
      latch_mask_o     <= hmask_d;
      latch_pulse_o    <= bump_act;
      oe_mask_o        <= en_d;
    end
  end

endmodule

/* dv/tb_pwm_channel_panel_controller.sv */
// Self-checking testbench for the PWM channel panel controller.
// A directed table of button events and register writes runs first, then random events
// under several flow-control phases. Depends on pwmpc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_pwm_channel_panel_controller;
  import pwmpc_pkg::*;

  localparam int NCH         = CHANNELS_DEF;
  localparam int DBITS       = DUTY_BITS_DEF;
  localparam int CH_W        = (NCH > 2) ? $clog2(NCH) : 1;
  localparam int RES_BITS    = CH_W + 2 * DBITS + 2 * NCH + 2;
  localparam int RES_W       = ((RES_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_SET = 150;

  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [NCH-1:0]   oe_mask;
    logic             latch_pulse;
    logic [NCH-1:0]   latch_mask;
    logic [DBITS-1:0] duty_word;
    logic             channel_active;
    logic [DBITS-1:0] duty;
    logic [CH_W-1:0]  channel;
  } panel_word_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  action;
    logic        select_mode;
    logic        coarse;
    logic        reg_sel;
    int unsigned value;
    bit          typed;
    panel_word_t typed_word;
  } panel_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic             pready;

  pwm_channel_panel_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the panel state.
  int unsigned    duty_mem [NCH];
  int unsigned    sel_chan;
  logic [NCH-1:0] oe_bits;
  int unsigned    held_word;
  logic [NCH-1:0] held_mask;
  int unsigned    step_cfg;
  int unsigned    limit_cfg;

  panel_word_t pending_panel [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned clamp_step(int unsigned v, int unsigned stp, bit down,
                                             int unsigned top);
    int unsigned r;
    if (down) begin
      r = (v < stp) ? 0 : v - stp;
    end else begin
      r = v + stp;
    end
    return (r > top) ? top : r;
  endfunction

  function automatic panel_word_t panel_after_event(logic [1:0] act, logic chan_mode,
                                                    logic crs);
    panel_word_t w;
    int unsigned stp;
    int unsigned lim;
    int unsigned d;
    stp = crs ? step_cfg : 1;
    lim = (limit_cfg > (1 << DBITS) - 1) ? (1 << DBITS) - 1 : limit_cfg;
    w.latch_pulse = 1'b0;
    if (act == ACT_PLUS || act == ACT_MINUS) begin
      w.latch_pulse = 1'b1;
      if (chan_mode) begin
        sel_chan = clamp_step(sel_chan, stp, act == ACT_MINUS, NCH - 1);
      end else begin
        d = clamp_step(duty_mem[sel_chan], stp, act == ACT_MINUS, lim);
        duty_mem[sel_chan] = d;
        held_word = d;
        held_mask = '0;
        held_mask[sel_chan] = 1'b1;
      end
    end else if (act == ACT_TOGGLE) begin
      oe_bits[sel_chan] = ~oe_bits[sel_chan];
    end
    w.channel        = CH_W'(sel_chan);
    w.duty           = DBITS'(duty_mem[sel_chan]);
    w.channel_active = oe_bits[sel_chan];
    w.duty_word      = DBITS'(held_word);
    w.latch_mask     = held_mask;
    w.oe_mask        = oe_bits;
    return w;
  endfunction

  task automatic compare_field(string name, int unsigned expv, int unsigned gotv);
    if (expv != gotv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, gotv);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Outputs are sampled mid-cycle; a word seen here transfers at the next rising edge.
  always @(negedge clk_i) begin
    panel_word_t exp_w;
    panel_word_t got_w;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_panel.size() == 0) begin
        $error("result word arrived with no expectation pending");
        fail_count++;
      end else begin
        exp_w = pending_panel.pop_front();
        got_w = m_tdata[RES_BITS-1:0];
        compare_field("channel", exp_w.channel, got_w.channel);
        compare_field("duty", exp_w.duty, got_w.duty);
        compare_field("channel_active", exp_w.channel_active, got_w.channel_active);
        compare_field("duty_word", exp_w.duty_word, got_w.duty_word);
        compare_field("latch_mask", exp_w.latch_mask, got_w.latch_mask);
        compare_field("latch_pulse", exp_w.latch_pulse, got_w.latch_pulse);
        compare_field("oe_mask", exp_w.oe_mask, got_w.oe_mask);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_event(logic [1:0] act, logic chan_mode, logic crs, bit typed,
                            panel_word_t typed_word);
    bit          taken;
    panel_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, crs, chan_mode, act};
    do begin
      @(negedge clk_i);
      taken = s_tready;
      @(posedge clk_i);
    end while (!taken);
    w = panel_after_event(act, chan_mode, crs);
    pending_panel.push_back(typed ? typed_word : w);
  endtask

  task automatic write_register(logic reg_sel, int unsigned value);
    bit done;
    s_tvalid <= 1'b0;
    while (pending_panel.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * reg_sel);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_COARSE_STEP) begin
      step_cfg = value & ((1 << CFG_STEP_W) - 1);
    end else begin
      limit_cfg = value & ((1 << CFG_LIMIT_W) - 1);
    end
    @(posedge clk_i);
  endtask

  function automatic panel_row_t event_row(logic [1:0] act, logic chan_mode, logic crs);
    panel_row_t r;
    r.kind        = ROW_EVENT;
    r.action      = act;
    r.select_mode = chan_mode;
    r.coarse      = crs;
    r.reg_sel     = REG_COARSE_STEP;
    r.value       = 0;
    r.typed       = 1'b0;
    r.typed_word  = '0;
    return r;
  endfunction

  function automatic panel_row_t checked_row(logic [1:0] act, logic chan_mode, logic crs,
                                             panel_word_t w);
    panel_row_t r;
    r            = event_row(act, chan_mode, crs);
    r.typed      = 1'b1;
    r.typed_word = w;
    return r;
  endfunction

  function automatic panel_row_t write_row(logic reg_sel, int unsigned value);
    panel_row_t r;
    r         = event_row(ACT_NONE, 1'b0, 1'b0);
    r.kind    = ROW_WRITE;
    r.reg_sel = reg_sel;
    r.value   = value;
    return r;
  endfunction

  initial begin
    panel_row_t  rows [$];
    panel_word_t w;
    int          k;
    int          plus_pct;
    int          pick;
    logic [1:0]  act;
    int          send_pcts [4];
    int          recv_pcts [4];

    send_pcts = '{0, 54, 0, 16};
    recv_pcts = '{0, 0, 54, 16};

    foreach (duty_mem[i]) duty_mem[i] = 1 << (DBITS - 1);
    sel_chan  = 0;
    oe_bits   = '1;
    held_word = 1 << (DBITS - 1);
    held_mask = NCH'(1);
    step_cfg  = STEP_RESET;
    limit_cfg = LIMIT_RESET;

    // The unused code reports the reset state untouched.
    w = '{oe_mask: 24'hFFFFFF, latch_pulse: 1'b0, latch_mask: 24'd1, duty_word: 10'd512,
          channel_active: 1'b1, duty: 10'd512, channel: 5'd0};
    rows.push_back(checked_row(ACT_NONE, 1'b0, 1'b0, w));
    // Moving the selection below channel 0 holds it there, and the latch still pulses.
    w.latch_pulse = 1'b1;
    rows.push_back(checked_row(ACT_MINUS, 1'b1, 1'b0, w));
    w.duty      = 10'd513;
    w.duty_word = 10'd513;
    rows.push_back(checked_row(ACT_PLUS, 1'b0, 1'b0, w));
    w.latch_pulse    = 1'b0;
    w.channel_active = 1'b0;
    w.oe_mask        = 24'hFFFFFE;
    rows.push_back(checked_row(ACT_TOGGLE, 1'b0, 1'b0, w));
    rows.push_back(event_row(ACT_PLUS, 1'b1, 1'b1));
    rows.push_back(event_row(ACT_PLUS, 1'b1, 1'b1));
    rows.push_back(event_row(ACT_PLUS, 1'b1, 1'b1));
    rows.push_back(event_row(ACT_PLUS, 1'b1, 1'b0));
    rows.push_back(event_row(ACT_TOGGLE, 1'b0, 1'b1));
    rows.push_back(write_row(REG_COARSE_STEP, 63));
    rows.push_back(write_row(REG_DUTY_LIMIT, 600));
    rows.push_back(event_row(ACT_PLUS, 1'b0, 1'b1));
    rows.push_back(event_row(ACT_PLUS, 1'b0, 1'b1));
    rows.push_back(write_row(REG_DUTY_LIMIT, 0));
    rows.push_back(event_row(ACT_PLUS, 1'b0, 1'b0));
    rows.push_back(write_row(REG_DUTY_LIMIT, 1023));
    rows.push_back(event_row(ACT_MINUS, 1'b0, 1'b1));
    rows.push_back(event_row(ACT_MINUS, 1'b1, 1'b1));
    rows.push_back(write_row(REG_COARSE_STEP, 0));
    rows.push_back(event_row(ACT_PLUS, 1'b0, 1'b1));
    rows.push_back(event_row(ACT_MINUS, 1'b1, 1'b1));
    rows.push_back(event_row(ACT_NONE, 1'b1, 1'b1));
    rows.push_back(write_row(REG_COARSE_STEP, 1));
    rows.push_back(event_row(ACT_PLUS, 1'b1, 1'b1));
    rows.push_back(event_row(ACT_MINUS, 1'b0, 1'b1));
    rows.push_back(event_row(ACT_NONE, 1'b0, 1'b0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        write_register(rows[i].reg_sel, rows[i].value);
      end else begin
        send_event(rows[i].action, rows[i].select_mode, rows[i].coarse, rows[i].typed,
                   rows[i].typed_word);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int sub = 0; sub < 3; sub++) begin
        k = ph * 3 + sub;
        case (k % 4)
          0: write_register(REG_COARSE_STEP, 63);
          1: write_register(REG_COARSE_STEP, 1);
          2: write_register(REG_COARSE_STEP, 0);
          default: write_register(REG_COARSE_STEP, $urandom_range(2, 62));
        endcase
        case ((k + k / 4) % 4)
          0: write_register(REG_DUTY_LIMIT, 1023);
          1: write_register(REG_DUTY_LIMIT, 1);
          2: write_register(REG_DUTY_LIMIT, $urandom_range(2, 1022));
          default: write_register(REG_DUTY_LIMIT, (sub == 1) ? 0 : $urandom_range(2, 1022));
        endcase
        plus_pct = $urandom_range(20, 80);
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          pick = $urandom_range(99);
          if (pick < 80) begin
            act = ($urandom_range(99) < plus_pct) ? ACT_PLUS : ACT_MINUS;
          end else if (pick < 95) begin
            act = ACT_TOGGLE;
          end else begin
            act = ACT_NONE;
          end
          send_event(act, $urandom_range(99) < 35, 1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_panel.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pwmpc_pkg.sv
hw/rtl/pwmpc_cfg.sv
hw/rtl/pwmpc_ctrl.sv
hw/rtl/pwmpc_dp.sv
hw/rtl/pwm_channel_panel_controller.sv
dv/tb_pwm_channel_panel_controller.sv
